// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker module.
// Each macro takes a label, the clock, the active-low reset, the property terms and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dddu_pkg.sv =====
// ----------------------------------------------------------------------------
// dddu_pkg
// Types and constants shared by the decimal digit display updater modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dddu_pkg;

	localparam int MAX_DIGITS = 18;
	localparam int SCORE_W    = 60;
	localparam int PLACE_W    = 5;
	localparam int CODE_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int DOT_W      = 8;
	localparam int BCD_W      = MAX_DIGITS * CODE_W;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	// Two binary bits enter the BCD converter per cycle.
	localparam int CONV_STEPS = SCORE_W / 2;
	localparam int STEP_W     = $clog2(CONV_STEPS);

	localparam logic [SCORE_W-1:0] SCORE_SAT  = 60'd999999999999999999;
	localparam logic [CODE_W-1:0]  BLANK_CODE = 4'd10;
	localparam logic [DOT_W-1:0]   DOT_RESET  = 8'd254;

	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_LEADING = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOT_POSITION  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANIMATE_ALL   = 8'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;  // input transfer this cycle
		logic load;    // start a conversion of the accepted score
		logic shift;   // one converter step
		logic emit;    // produce the result for the current place
	} cmd_t;

	typedef struct packed {
		logic refresh;    // the presented item needs a display update
		logic out_free;   // output register can take a result this cycle
		logic emit_last;  // current place is the highest displayed one
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dddu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dddu_ctrl
// Sequencer: accepts items, runs the BCD converter, then steps the places.
// ----------------------------------------------------------------------------
`default_nettype none

module dddu_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire dddu_pkg::sts_t sts,
	output dddu_pkg::cmd_t   cmd
);

	dddu_pkg::state_t state_q;
	dddu_pkg::state_t state_d;
	logic [dddu_pkg::STEP_W-1:0] step_q;
	logic conv_done;

	assign conv_done = (step_q == dddu_pkg::STEP_W'(dddu_pkg::CONV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dddu_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dddu_pkg::ST_CONVERT) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dddu_pkg::ST_IDLE: begin
				if (in_valid && sts.refresh) begin
					state_d = dddu_pkg::ST_CONVERT;
				end
			end
			dddu_pkg::ST_CONVERT: begin
				if (conv_done) begin
					state_d = dddu_pkg::ST_EMIT;
				end
			end
			dddu_pkg::ST_EMIT: begin
				if (sts.out_free && sts.emit_last) begin
					state_d = dddu_pkg::ST_IDLE;
				end
			end
			default: state_d = dddu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			dddu_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				cmd.load   = in_valid && sts.refresh;
			end
			dddu_pkg::ST_CONVERT: begin
				cmd.shift = 1'b1;
			end
			dddu_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dddu_datapath.sv =====
// ----------------------------------------------------------------------------
// dddu_datapath
// Configuration registers, change detection, shift-add-3 BCD converter,
// per-place glyph logic, shown-code store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dddu_datapath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	input  wire [dddu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [dddu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire [dddu_pkg::SCORE_W-1:0]         score_value,
	input  wire dddu_pkg::cmd_t                 cmd,
	output dddu_pkg::sts_t                      sts,
	input  wire                                 out_ready,
	output logic                                out_valid,
	output logic [dddu_pkg::PLACE_W-1:0]        digit_place,
	output logic [dddu_pkg::CODE_W-1:0]         digit_code,
	output logic                                digit_changed,
	output logic [dddu_pkg::CODE_W-1:0]         old_code,
	output logic                                old_valid,
	output logic                                comma_visible,
	output logic                                last_digit
);

	// One shift-add-3 step: correct every digit, then shift in one binary bit.
	function automatic logic [dddu_pkg::BCD_W-1:0] dabble(
		input logic [dddu_pkg::BCD_W-1:0] bcd,
		input logic                       bit_in
	);
		logic [dddu_pkg::BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < dddu_pkg::MAX_DIGITS; i++) begin
			if (adj[i*dddu_pkg::CODE_W +: dddu_pkg::CODE_W] >= 4'd5) begin
				adj[i*dddu_pkg::CODE_W +: dddu_pkg::CODE_W] =
					adj[i*dddu_pkg::CODE_W +: dddu_pkg::CODE_W] + 4'd3;
			end
		end
		return {adj[dddu_pkg::BCD_W-2:0], bit_in};
	endfunction

	// Configuration
	logic [dddu_pkg::COUNT_W-1:0] digit_count_q;
	logic                         blank_leading_q;
	logic [dddu_pkg::DOT_W-1:0]   dot_position_q;
	logic                         animate_all_q;

	// Item state
	logic [dddu_pkg::SCORE_W-1:0] stored_score_q;
	logic                         pending_q;
	logic [dddu_pkg::DOT_W-1:0]   applied_dot_q;

	// Converter
	logic [dddu_pkg::SCORE_W-1:0] bin_q;
	logic [dddu_pkg::BCD_W-1:0]   bcd_q;
	logic [dddu_pkg::CODE_W-1:0]  digit_arr [dddu_pkg::MAX_DIGITS];

	// Place stepping and shown codes
	logic [dddu_pkg::PLACE_W-1:0] place_q;
	logic [1:0]                   mod3_q;
	logic                         shown_valid_q [dddu_pkg::MAX_DIGITS];
	logic [dddu_pkg::CODE_W-1:0]  shown_code_q [dddu_pkg::MAX_DIGITS];

	logic                         out_valid_q;

	logic [dddu_pkg::COUNT_W-1:0] count;
	logic [dddu_pkg::MAX_DIGITS-1:0] upper_nz;
	logic                         any_upper;
	logic                         dot_ok;
	logic [dddu_pkg::DOT_W:0]     dot_sum;
	logic                         near_dot;
	logic                         is_blank;
	logic [dddu_pkg::CODE_W-1:0]  cur_digit;
	logic [dddu_pkg::CODE_W-1:0]  new_code;
	logic                         prev_valid;
	logic [dddu_pkg::CODE_W-1:0]  prev_code;
	logic                         comma_place;
	logic                         place_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q   <= dddu_pkg::COUNT_W'(1);
			blank_leading_q <= 1'b0;
			dot_position_q  <= '0;
			animate_all_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dddu_pkg::REG_DIGIT_COUNT:   digit_count_q   <= cfg_data[dddu_pkg::COUNT_W-1:0];
				dddu_pkg::REG_BLANK_LEADING: blank_leading_q <= cfg_data[0];
				dddu_pkg::REG_DOT_POSITION:  dot_position_q  <= cfg_data[dddu_pkg::DOT_W-1:0];
				dddu_pkg::REG_ANIMATE_ALL:   animate_all_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sts.refresh = pending_q || (score_value != stored_score_q)
		|| (dot_position_q != applied_dot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_score_q <= '0;
			pending_q      <= 1'b1;
			applied_dot_q  <= dddu_pkg::DOT_RESET;
		end else if (cmd.accept) begin
			// Any refresh owed is started by this very transfer.
			stored_score_q <= score_value;
			applied_dot_q  <= dot_position_q;
			pending_q      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= (score_value > dddu_pkg::SCORE_SAT) ? dddu_pkg::SCORE_SAT : score_value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[dddu_pkg::SCORE_W-3:0], 2'b00};
			bcd_q <= dabble(dabble(bcd_q, bin_q[dddu_pkg::SCORE_W-1]),
				bin_q[dddu_pkg::SCORE_W-2]);
		end
	end

	for (genvar g = 0; g < dddu_pkg::MAX_DIGITS; g++) begin : g_digits
		assign digit_arr[g] = bcd_q[g*dddu_pkg::CODE_W +: dddu_pkg::CODE_W];
	end

	always_comb begin
		if (digit_count_q == '0) begin
			count = dddu_pkg::COUNT_W'(1);
		end else if (digit_count_q > dddu_pkg::COUNT_W'(dddu_pkg::MAX_DIGITS)) begin
			count = dddu_pkg::COUNT_W'(dddu_pkg::MAX_DIGITS);
		end else begin
			count = digit_count_q;
		end
	end

	// A zero is a leading zero when no displayed digit at or above it is nonzero.
	always_comb begin
		for (int i = 0; i < dddu_pkg::MAX_DIGITS; i++) begin
			upper_nz[i] = (digit_arr[i] != '0)
				&& (dddu_pkg::PLACE_W'(i) >= place_q)
				&& (dddu_pkg::PLACE_W'(i) < count);
		end
	end

	assign any_upper = |upper_nz;
	assign dot_ok    = {1'b0, applied_dot_q} < {4'b0, count};
	assign dot_sum   = {4'b0, place_q} + {1'b0, applied_dot_q};
	assign near_dot  = dot_ok && (dot_sum <= {4'b0, count});

	assign cur_digit   = digit_arr[place_q];
	assign is_blank    = blank_leading_q && (place_q != '0) && !any_upper && !near_dot;
	assign new_code    = is_blank ? dddu_pkg::BLANK_CODE : cur_digit;
	assign prev_valid  = shown_valid_q[place_q];
	assign prev_code   = shown_code_q[place_q];
	assign comma_place = (place_q != '0) && (mod3_q == 2'd0);
	assign place_last  = (place_q == count - 1'b1);

	assign sts.emit_last = place_last;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_q     <= '0;
			mod3_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < dddu_pkg::MAX_DIGITS; i++) begin
				shown_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.load) begin
				place_q <= '0;
				mod3_q  <= '0;
			end else if (cmd.emit) begin
				place_q <= place_q + 1'b1;
				mod3_q  <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 1'b1;
				shown_valid_q[place_q] <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			shown_code_q[place_q] <= new_code;
			digit_place   <= place_q;
			digit_code    <= new_code;
			digit_changed <= !prev_valid || (prev_code != new_code) || animate_all_q;
			old_code      <= prev_valid ? prev_code : '0;
			old_valid     <= prev_valid;
			comma_visible <= comma_place && !is_blank;
			last_digit    <= place_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_digit_display_updater.sv =====
// ----------------------------------------------------------------------------
// decimal_digit_display_updater
// Score to decimal glyph updater with leading-zero blanking and commas.
// ----------------------------------------------------------------------------
// Each accepted score is compared with the one held and with the dot position
// last applied; if neither has changed (and no refresh is owed since reset) the
// transfer produces nothing. Otherwise the score, saturated to eighteen nines,
// goes through a shift-add-3 converter taking two bits per cycle, then one
// result per displayed place leaves, ones digit first, at one per cycle while
// the output is taken; the number of places is the digit count clamped to one
// through eighteen. The input is not ready again until the last place has
// entered the output register. Configuration writes are always accepted and
// must only be made while the block is idle.
`default_nettype none

module decimal_digit_display_updater (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [dddu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [dddu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire [dddu_pkg::SCORE_W-1:0]         score_value,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [dddu_pkg::PLACE_W-1:0]        digit_place,
	output logic [dddu_pkg::CODE_W-1:0]         digit_code,
	output logic                                digit_changed,
	output logic [dddu_pkg::CODE_W-1:0]         old_code,
	output logic                                old_valid,
	output logic                                comma_visible,
	output logic                                last_digit
);

	dddu_pkg::cmd_t cmd;
	dddu_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	dddu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dddu_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.score_value   (score_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.digit_place   (digit_place),
		.digit_code    (digit_code),
		.digit_changed (digit_changed),
		.old_code      (old_code),
		.old_valid     (old_valid),
		.comma_visible (comma_visible),
		.last_digit    (last_digit)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/dddu_checker.sv =====
// ----------------------------------------------------------------------------
// dddu_checker
// Port-level checks on the result stream of the display updater.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dddu_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire [dddu_pkg::PLACE_W-1:0]      digit_place,
	input wire [dddu_pkg::CODE_W-1:0]       digit_code,
	input wire                              digit_changed,
	input wire [dddu_pkg::CODE_W-1:0]       old_code,
	input wire                              old_valid,
	input wire                              comma_visible
);

	// A result held back by the consumer must not move.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(digit_place) && $stable(digit_code), "result changed while stalled")

	// A place never shown before always counts as changed and carries no old code.
	`ASSERT_IMPLIES(a_first_show, clk, arst_n, out_valid && !old_valid, digit_changed && (old_code == '0), "first show of a place is not flagged changed")

	// The ones digit is never blank and never carries a separator.
	`ASSERT_IMPLIES(a_ones_place, clk, arst_n, out_valid && (digit_place == '0), (digit_code != dddu_pkg::BLANK_CODE) && !comma_visible, "ones place blank or with separator")

	// A separator is never shown beside a blank glyph.
	`ASSERT_IMPLIES(a_comma_blank, clk, arst_n, out_valid && (digit_code == dddu_pkg::BLANK_CODE), !comma_visible, "separator shown over a blank")

endmodule

bind decimal_digit_display_updater dddu_checker u_dddu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.digit_place   (digit_place),
	.digit_code    (digit_code),
	.digit_changed (digit_changed),
	.old_code      (old_code),
	.old_valid     (old_valid),
	.comma_visible (comma_visible)
);

`default_nettype wire
